[rtl/pala_pkg.sv]
// ----------------------------------------------------------------------------
// pala_pkg: shared constants for the polyline arc length accumulator
// Holds the queue depth between the front and back parts and the helper
// that rounds a field width up to whole bytes for the stream ports.
// ----------------------------------------------------------------------------
package pala_pkg;

  // Number of entries in the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Width of a stream data bus that carries the given number of field bits.
  function automatic int unsigned byte_pad(input int unsigned bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

[rtl/pala_front.sv]
// ----------------------------------------------------------------------------
// pala_front: point intake and coordinate differencing
// Accepts points, keeps the previous point and hands the absolute x and y
// steps plus the first point flag to the queue.
// ----------------------------------------------------------------------------
module pala_front import pala_pkg::*; #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [COORD_BITS-1:0]   x_coord_i,
  input  logic [COORD_BITS-1:0]   y_coord_i,
  input  logic                    first_point_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output logic [2*COORD_BITS:0]   q_data_o
);

  logic [COORD_BITS-1:0] prev_x_q;
  logic [COORD_BITS-1:0] prev_y_q;
  logic signed [COORD_BITS:0] diff_x;
  logic signed [COORD_BITS:0] diff_y;
  logic [COORD_BITS-1:0] mag_x;
  logic [COORD_BITS-1:0] mag_y;

  // Differences are taken one bit wider so that they never wrap; the
  // magnitude always fits back into COORD_BITS bits.
  always_comb begin
    diff_x = $signed({x_coord_i[COORD_BITS-1], x_coord_i})
           - $signed({prev_x_q[COORD_BITS-1], prev_x_q});
    diff_y = $signed({y_coord_i[COORD_BITS-1], y_coord_i})
           - $signed({prev_y_q[COORD_BITS-1], prev_y_q});
    mag_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
    mag_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_data_o   = {first_point_i, mag_y, mag_x};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else if (q_push_o) begin
      prev_x_q <= x_coord_i;
      prev_y_q <= y_coord_i;
    end
  end

endmodule

[rtl/pala_fifo.sv]
// ----------------------------------------------------------------------------
// pala_fifo: short queue between the front and back parts
// A small register queue so that intake and arithmetic stall independently.
// ----------------------------------------------------------------------------
module pala_fifo import pala_pkg::*; #(
  parameter int unsigned WIDTH = 49
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/pala_back.sv]
// ----------------------------------------------------------------------------
// pala_back: distance and running length
// Squares the steps, takes the floor square root one result bit per cycle,
// adds it to the saturating running length and holds the result for output.
// ----------------------------------------------------------------------------
module pala_back import pala_pkg::*; #(
  parameter int unsigned COORD_BITS  = 24,
  parameter int unsigned LENGTH_BITS = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  logic [2*COORD_BITS:0]   q_data_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [LENGTH_BITS-1:0]  arc_length_o,
  output logic                    length_saturated_o
);

  localparam int unsigned ROOT_W = COORD_BITS + 1;
  localparam int unsigned PAIRS  = COORD_BITS + 1;
  localparam int unsigned RAD_W  = 2 * PAIRS;
  localparam int unsigned REM_W  = COORD_BITS + 3;
  localparam int unsigned CNT_W  = $clog2(PAIRS);
  localparam int unsigned SUM_W  = ((LENGTH_BITS > ROOT_W) ? LENGTH_BITS : ROOT_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_ROOT,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [COORD_BITS-1:0]   ax_q;
  logic [COORD_BITS-1:0]   ay_q;
  logic                    first_q;
  logic [2*COORD_BITS-1:0] sq_x_q;
  logic [2*COORD_BITS-1:0] sq_y_q;
  logic [RAD_W-1:0]        rad_q;
  logic [REM_W-1:0]        rem_q;
  logic [ROOT_W-1:0]       root_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [LENGTH_BITS-1:0]  run_q;
  logic                    sat_q;
  logic                    out_valid_q;
  logic [LENGTH_BITS-1:0]  out_len_q;
  logic                    out_sat_q;

  logic [REM_W-1:0] rem_shift;
  logic [REM_W-1:0] trial;
  logic             root_bit;
  logic [SUM_W-1:0] acc_sum;
  logic             acc_ovf;
  logic             out_free;
  logic             out_load;

  always_comb begin
    rem_shift = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial     = {root_q, 2'b01};
    root_bit  = (rem_shift >= trial);
    acc_sum   = SUM_W'(run_q) + SUM_W'(root_q);
    acc_ovf   = |acc_sum[SUM_W-1:LENGTH_BITS];
    out_free  = !out_valid_q || out_ready_i;
    out_load  = (state_q == ST_DONE) && out_free;
  end

  assign q_pop_o            = (state_q == ST_IDLE) && !q_empty_i;
  assign out_valid_o        = out_valid_q;
  assign arc_length_o       = out_len_q;
  assign length_saturated_o = out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ax_q        <= '0;
      ay_q        <= '0;
      first_q     <= 1'b0;
      sq_x_q      <= '0;
      sq_y_q      <= '0;
      rad_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      cnt_q       <= '0;
      run_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_len_q   <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            ax_q    <= q_data_i[COORD_BITS-1:0];
            ay_q    <= q_data_i[2*COORD_BITS-1:COORD_BITS];
            first_q <= q_data_i[2*COORD_BITS];
            state_q <= q_data_i[2*COORD_BITS] ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          sq_x_q  <= ax_q * ax_q;
          sq_y_q  <= ay_q * ay_q;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          rad_q   <= RAD_W'(sq_x_q) + RAD_W'(sq_y_q);
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= CNT_W'(PAIRS - 1);
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          // Restoring square root: one radicand bit pair per cycle.
          rem_q  <= root_bit ? rem_shift - trial : rem_shift;
          root_q <= {root_q[ROOT_W-2:0], root_bit};
          rad_q  <= rad_q << 2;
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q     <= ST_IDLE;
            if (first_q) begin
              run_q     <= '0;
              sat_q     <= 1'b0;
              out_len_q <= '0;
              out_sat_q <= 1'b0;
            end else if (acc_ovf) begin
              run_q     <= '1;
              sat_q     <= 1'b1;
              out_len_q <= '1;
              out_sat_q <= 1'b1;
            end else begin
              run_q     <= acc_sum[LENGTH_BITS-1:0];
              out_len_q <= acc_sum[LENGTH_BITS-1:0];
              out_sat_q <= sat_q;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/polyline_arc_length_accumulator.sv]
// ----------------------------------------------------------------------------
// polyline_arc_length_accumulator: cumulative path length of a point stream
// Returns, for every trajectory point, the length of the path walked from
// the first point of the trajectory, with a saturating running sum.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  tdata (low bit up)             tuser
//   s_axis    in         x_coord, y_coord               first_point
//   m_axis    out        arc_length                     length_saturated
//
// In the back part each point is fetched from the queue, its steps are
// squared, the squares are summed and the square root comes out of a
// restoring loop one result bit per cycle; a last step adds it to the
// running length and writes the output register. A first point skips the
// arithmetic. Reset is asynchronous and active low; it clears the
// previous point to the origin and the running length to zero.
// A stalled output holds its beat while the back part finishes the next
// point and the front part keeps filling the queue.
module polyline_arc_length_accumulator import pala_pkg::*; #(
  parameter int unsigned COORD_BITS  = 24,
  parameter int unsigned LENGTH_BITS = 40
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input point stream.
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata: x_coord [COORD_BITS-1:0], y_coord [2*COORD_BITS-1:COORD_BITS]
  input  logic [byte_pad(2*COORD_BITS)-1:0]     s_axis_tdata_i,
  // tuser: first_point
  input  logic                                  s_axis_tuser_i,
  // Output length stream.
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // tdata: arc_length [LENGTH_BITS-1:0]
  output logic [byte_pad(LENGTH_BITS)-1:0]      m_axis_tdata_o,
  // tuser: length_saturated
  output logic                                  m_axis_tuser_o
);

  localparam int unsigned ENTRY_W = 2 * COORD_BITS + 1;
  localparam int unsigned OUT_W   = byte_pad(LENGTH_BITS);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;
  logic [LENGTH_BITS-1:0] arc_length;

  // The front part differences each point against the previous one.
  pala_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .x_coord_i     (s_axis_tdata_i[COORD_BITS-1:0]),
    .y_coord_i     (s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .first_point_i (s_axis_tuser_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  // The queue decouples intake from the long square root.
  pala_fifo #(
    .WIDTH(ENTRY_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  // The back part computes the step length and keeps the running sum.
  pala_back #(
    .COORD_BITS (COORD_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_empty_i          (q_empty),
    .q_data_i           (q_rdata),
    .q_pop_o            (q_pop),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .arc_length_o       (arc_length),
    .length_saturated_o (m_axis_tuser_o)
  );

  // Padding bits above the length are zero.
  assign m_axis_tdata_o = OUT_W'(arc_length);

endmodule

[rtl/pala_sva.sv]
// ----------------------------------------------------------------------------
// pala_sva: port-level checks for the polyline arc length accumulator
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module pala_sva import pala_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 40
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [byte_pad(LENGTH_BITS)-1:0] m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);

  logic [3:0] pending_q;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  // Points taken in whose length has not yet left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_beat && !out_beat) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // A stalled output beat keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output beat changed while stalled");

  // A saturated length is the largest value.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> &m_axis_tdata_o[LENGTH_BITS-1:0])
    else $error("saturated length below maximum");

  // No output beat without a point behind it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pending_q != '0)
    else $error("output beat without a pending point");

  // Nothing is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid right after reset");

endmodule

bind polyline_arc_length_accumulator pala_sva #(
  .LENGTH_BITS(LENGTH_BITS)
) u_pala_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
